FILE: rtl/cpsat_pkg.sv
// shared types and constants for the convex polygon separating axis test
package cpsat_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int IN_BITS          = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH_I,
        ST_FETCH_J,
        ST_AXIS,
        ST_PROJ,
        ST_WAIT1,
        ST_WAIT2,
        ST_COMPARE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic fetch_i;
        logic fetch_j;
        logic cap_i;
        logic cap_axis;
        logic proj_issue;
        logic next_edge;
        logic next_side;
        logic publish;
        logic hit;
    } cmd_t;

    typedef struct packed {
        logic closes_b;
        logic empty;
        logic edge_last;
        logic side_b;
        logic proj_last;
        logic separated;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/cpsat_ctrl.sv
// sequencer for the axis walk: fetch edge, build axis, project, compare
module cpsat_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cpsat_pkg::sts_t   sts,
    output cpsat_pkg::cmd_t   cmd
);
    import cpsat_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   hit_reg;
    logic   hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hit_next   = hit_reg;
        cmd        = '0;
        cmd.hit    = hit_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && sts.closes_b)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.empty)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_FETCH_I;
                end
            end
            ST_FETCH_I:
            begin
                cmd.fetch_i = 1'b1;
                state_next  = ST_FETCH_J;
            end
            ST_FETCH_J:
            begin
                cmd.fetch_j = 1'b1;
                cmd.cap_i   = 1'b1;
                state_next  = ST_AXIS;
            end
            ST_AXIS:
            begin
                cmd.cap_axis = 1'b1;
                state_next   = ST_PROJ;
            end
            ST_PROJ:
            begin
                cmd.proj_issue = 1'b1;
                if (sts.proj_last)
                begin
                    state_next = ST_WAIT1;
                end
            end
            ST_WAIT1:
            begin
                state_next = ST_WAIT2;
            end
            ST_WAIT2:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (sts.separated)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (sts.edge_last && sts.side_b)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.edge_last)
                begin
                    cmd.next_side = 1'b1;
                    state_next    = ST_FETCH_I;
                end
                else
                begin
                    cmd.next_edge = 1'b1;
                    state_next    = ST_FETCH_I;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/cpsat_dp.sv
// vertex stores, append bookkeeping, projection pipeline and result register
module cpsat_dp #(
    parameter int MAX_VERTICES = cpsat_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpsat_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_accept,
    input  logic                                 func,
    input  logic signed [cpsat_pkg::IN_BITS-1:0] vertex_x,
    input  logic signed [cpsat_pkg::IN_BITS-1:0] vertex_y,
    input  logic                                 last_vertex,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 collide,
    output logic                                 empty_polygon,
    output logic                                 vertex_overflow,
    input  cpsat_pkg::cmd_t                      cmd,
    output cpsat_pkg::sts_t                      sts
);
    import cpsat_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int AXW = C + 1;
    localparam int PW  = 2 * C + 1;
    localparam int SW  = 2 * C + 2;

    // vertex stores, word = {y, x}
    logic [2*C-1:0] mem_a [MAX_VERTICES];
    logic [2*C-1:0] mem_b [MAX_VERTICES];
    logic [2*C-1:0] rd_a_reg;
    logic [2*C-1:0] rd_b_reg;

    logic [CW-1:0] cnt_a_reg;
    logic [CW-1:0] cnt_b_reg;
    logic          closed_a_reg;
    logic          closed_b_reg;
    logic          ov_a_reg;
    logic          ov_b_reg;

    // append path
    logic signed [31:0] x_ext;
    logic signed [31:0] y_ext;
    logic [2*C-1:0]     wr_word;
    logic [CW-1:0]      cnt_cur;
    logic [CW-1:0]      cnt_eff;
    logic               closed_cur;
    logic               room;

    assign x_ext      = 32'(vertex_x);
    assign y_ext      = 32'(vertex_y);
    assign wr_word    = {y_ext[C-1:0], x_ext[C-1:0]};
    assign cnt_cur    = func ? cnt_b_reg : cnt_a_reg;
    assign closed_cur = func ? closed_b_reg : closed_a_reg;
    assign cnt_eff    = closed_cur ? '0 : cnt_cur;
    assign room       = cnt_eff < CW'(MAX_VERTICES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            closed_a_reg <= 1'b1;
            closed_b_reg <= 1'b1;
            ov_a_reg     <= 1'b0;
            ov_b_reg     <= 1'b0;
        end
        else if (in_accept)
        begin
            if (func)
            begin
                cnt_b_reg    <= room ? cnt_eff + CW'(1) : cnt_eff;
                ov_b_reg     <= (ov_b_reg & ~closed_b_reg) | ~room;
                closed_b_reg <= last_vertex;
            end
            else
            begin
                cnt_a_reg    <= room ? cnt_eff + CW'(1) : cnt_eff;
                ov_a_reg     <= (ov_a_reg & ~closed_a_reg) | ~room;
                closed_a_reg <= last_vertex;
            end
        end
    end

    // walk counters
    logic          side_reg;
    logic [CW-1:0] edge_i_reg;
    logic [CW-1:0] proj_k_reg;
    logic [CW-1:0] n_side;
    logic [CW-1:0] edge_inc;
    logic [CW-1:0] edge_j;
    logic [CW-1:0] n_max;
    logic [CW-1:0] rd_addr;

    assign n_side   = side_reg ? cnt_b_reg : cnt_a_reg;
    assign edge_inc = edge_i_reg + CW'(1);
    assign edge_j   = (edge_inc == n_side) ? '0 : edge_inc;
    assign n_max    = (cnt_a_reg > cnt_b_reg) ? cnt_a_reg : cnt_b_reg;

    always_comb
    begin
        if (cmd.fetch_i)
        begin
            rd_addr = edge_i_reg;
        end
        else if (cmd.fetch_j)
        begin
            rd_addr = edge_j;
        end
        else
        begin
            rd_addr = proj_k_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && room && !func)
        begin
            mem_a[cnt_eff[AW-1:0]] <= wr_word;
        end
        if (in_accept && room && func)
        begin
            mem_b[cnt_eff[AW-1:0]] <= wr_word;
        end
        rd_a_reg <= mem_a[rd_addr[AW-1:0]];
        rd_b_reg <= mem_b[rd_addr[AW-1:0]];
    end

    // edge vertices and axis
    logic [2*C-1:0]        rd_edge;
    logic [2*C-1:0]        vi_reg;
    logic signed [C-1:0]   vi_x;
    logic signed [C-1:0]   vi_y;
    logic signed [C-1:0]   vj_x;
    logic signed [C-1:0]   vj_y;
    logic signed [AXW-1:0] axis_x_reg;
    logic signed [AXW-1:0] axis_y_reg;

    assign rd_edge = side_reg ? rd_b_reg : rd_a_reg;
    assign vi_x    = vi_reg[C-1:0];
    assign vi_y    = vi_reg[2*C-1:C];
    assign vj_x    = rd_edge[C-1:0];
    assign vj_y    = rd_edge[2*C-1:C];

    always_ff @(posedge clk)
    begin
        if (cmd.cap_i)
        begin
            vi_reg <= rd_edge;
        end
        if (cmd.cap_axis)
        begin
            // perpendicular of the edge: (-ey, ex)
            axis_x_reg <= AXW'(vi_y) - AXW'(vj_y);
            axis_y_reg <= AXW'(vj_x) - AXW'(vi_x);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg   <= 1'b0;
            edge_i_reg <= '0;
            proj_k_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                side_reg   <= 1'b0;
                edge_i_reg <= '0;
            end
            else if (cmd.next_side)
            begin
                side_reg   <= 1'b1;
                edge_i_reg <= '0;
            end
            else if (cmd.next_edge)
            begin
                edge_i_reg <= edge_inc;
            end
            if (cmd.cap_axis)
            begin
                proj_k_reg <= '0;
            end
            else if (cmd.proj_issue)
            begin
                proj_k_reg <= proj_k_reg + CW'(1);
            end
        end
    end

    // projection pipeline: read, multiply, sum and min/max
    logic                 v1a_reg;
    logic                 v1b_reg;
    logic                 v2a_reg;
    logic                 v2b_reg;
    logic                 have_a_reg;
    logic                 have_b_reg;
    logic signed [C-1:0]  ra_x;
    logic signed [C-1:0]  ra_y;
    logic signed [C-1:0]  rb_x;
    logic signed [C-1:0]  rb_y;
    logic signed [PW-1:0] pax_reg;
    logic signed [PW-1:0] pay_reg;
    logic signed [PW-1:0] pbx_reg;
    logic signed [PW-1:0] pby_reg;
    logic signed [SW-1:0] da;
    logic signed [SW-1:0] db;
    logic signed [SW-1:0] lo_a_reg;
    logic signed [SW-1:0] hi_a_reg;
    logic signed [SW-1:0] lo_b_reg;
    logic signed [SW-1:0] hi_b_reg;

    assign ra_x = rd_a_reg[C-1:0];
    assign ra_y = rd_a_reg[2*C-1:C];
    assign rb_x = rd_b_reg[C-1:0];
    assign rb_y = rd_b_reg[2*C-1:C];
    assign da   = SW'(pax_reg) + SW'(pay_reg);
    assign db   = SW'(pbx_reg) + SW'(pby_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1a_reg    <= 1'b0;
            v1b_reg    <= 1'b0;
            v2a_reg    <= 1'b0;
            v2b_reg    <= 1'b0;
            have_a_reg <= 1'b0;
            have_b_reg <= 1'b0;
        end
        else
        begin
            v1a_reg <= cmd.proj_issue && (proj_k_reg < cnt_a_reg);
            v1b_reg <= cmd.proj_issue && (proj_k_reg < cnt_b_reg);
            v2a_reg <= v1a_reg;
            v2b_reg <= v1b_reg;
            if (cmd.cap_axis)
            begin
                have_a_reg <= 1'b0;
                have_b_reg <= 1'b0;
            end
            else
            begin
                have_a_reg <= have_a_reg | v2a_reg;
                have_b_reg <= have_b_reg | v2b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pax_reg <= PW'(ra_x) * PW'(axis_x_reg);
        pay_reg <= PW'(ra_y) * PW'(axis_y_reg);
        pbx_reg <= PW'(rb_x) * PW'(axis_x_reg);
        pby_reg <= PW'(rb_y) * PW'(axis_y_reg);
        if (v2a_reg)
        begin
            if (!have_a_reg || da < lo_a_reg)
            begin
                lo_a_reg <= da;
            end
            if (!have_a_reg || da > hi_a_reg)
            begin
                hi_a_reg <= da;
            end
        end
        if (v2b_reg)
        begin
            if (!have_b_reg || db < lo_b_reg)
            begin
                lo_b_reg <= db;
            end
            if (!have_b_reg || db > hi_b_reg)
            begin
                hi_b_reg <= db;
            end
        end
    end

    // result register
    logic out_valid_reg;
    logic collide_reg;
    logic empty_reg;
    logic overflow_reg;
    logic empty_w;

    assign empty_w = (cnt_a_reg == '0) || (cnt_b_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            collide_reg  <= cmd.hit;
            empty_reg    <= empty_w;
            overflow_reg <= ov_a_reg | ov_b_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign collide         = collide_reg;
    assign empty_polygon   = empty_reg;
    assign vertex_overflow = overflow_reg;

    assign sts.closes_b  = func & last_vertex;
    assign sts.empty     = empty_w;
    assign sts.edge_last = (edge_inc == n_side);
    assign sts.side_b    = side_reg;
    assign sts.proj_last = (proj_k_reg == n_max - CW'(1));
    assign sts.separated = (hi_a_reg < lo_b_reg) || (hi_b_reg < lo_a_reg);
    assign sts.out_free  = ~out_valid_reg | out_ready;

endmodule

FILE: rtl/convex_polygon_sat_collision.sv
// separating axis collision test for two convex polygons, top level
//
//  channel | signals                                        | moves
//  --------+------------------------------------------------+------------------------------
//  in      | in_valid in_ready func vertex_x vertex_y       | one vertex request per accept
//          | last_vertex                                    |
//  out     | out_valid out_ready collide empty_polygon      | one result per closed polygon B
//          | vertex_overflow                                |
//
// a request that closes b starts the test and holds in_ready low until the
// result is loaded into the output register
// each axis is one pass over max(na, nb) vertices through the single projection pipe,
// up to na + nb axes, with an early exit on the first separating axis
// reset clears counts, flags and the sequencer; vertex stores need no clearing
// a result may wait in the output register while new vertices are accepted
module convex_polygon_sat_collision #(
    parameter int MAX_VERTICES = cpsat_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpsat_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 func,
    input  logic signed [cpsat_pkg::IN_BITS-1:0] vertex_x,
    input  logic signed [cpsat_pkg::IN_BITS-1:0] vertex_y,
    input  logic                                 last_vertex,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 collide,
    output logic                                 empty_polygon,
    output logic                                 vertex_overflow
);
    import cpsat_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_accept;

    assign in_accept = in_valid & in_ready;

    cpsat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpsat_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_accept       (in_accept),
        .func            (func),
        .vertex_x        (vertex_x),
        .vertex_y        (vertex_y),
        .last_vertex     (last_vertex),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .collide         (collide),
        .empty_polygon   (empty_polygon),
        .vertex_overflow (vertex_overflow),
        .cmd             (cmd),
        .sts             (sts)
    );

    // a result is only loaded when the output register can take it
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> sts.out_free)
        else $error("result loaded over a pending one");

    // no vertex request is taken while the stores are being walked
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fetch_i || cmd.fetch_j || cmd.cap_axis || cmd.proj_issue) |-> !in_ready)
        else $error("request accepted during test");

    // an empty polygon never reports a collision
    a_empty_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_polygon) |-> !collide)
        else $error("collision reported for empty polygon");

    // a request closing b is followed by the test sequence
    a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func && last_vertex) |=> !in_ready)
        else $error("test did not start after b closed");

endmodule

FILE: test/convex_polygon_sat_collision_test.sv
// self-checking testbench for the convex polygon separating axis collision block
module convex_polygon_sat_collision_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpsat_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;
    localparam int CB = COORD_BITS_DEF;
    localparam int PHASE_ITEMS = 425;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 1000;
    localparam logic FUNC_A = 1'b0;
    localparam logic FUNC_B = 1'b1;

    typedef logic signed [IN_BITS-1:0] coord_t;

    typedef struct {
        logic   func;
        coord_t x;
        coord_t y;
        logic   last;
    } vertex_req_t;

    typedef struct {
        logic collide;
        logic empty;
        logic overflow;
    } verdict_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid = 1'b0;
    logic   in_ready;
    logic   func = FUNC_A;
    coord_t vertex_x = '0;
    coord_t vertex_y = '0;
    logic   last_vertex = 1'b0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    logic   collide;
    logic   empty_polygon;
    logic   vertex_overflow;

    vertex_req_t vertex_feed[$];
    verdict_t    verdicts[$];
    int          fed = 0;
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_request = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    // shadow copy of both polygons, coordinates already wrapped
    longint poly_x[2][NV];
    longint poly_y[2][NV];
    int     poly_n[2];
    bit     poly_closed[2];
    bit     poly_ovf[2];

    convex_polygon_sat_collision DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .last_vertex    (last_vertex),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .collide        (collide),
        .empty_polygon  (empty_polygon),
        .vertex_overflow(vertex_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint wrap_coord(coord_t raw);
        longint v;
        v = raw;
        return (v <<< (64 - CB)) >>> (64 - CB);
    endfunction

    // true when no edge of this polygon gives a separating axis
    function automatic bit axes_overlap(int side);
        longint ax;
        longint ay;
        longint d;
        longint lo[2];
        longint hi[2];
        int     j;
        for (int i = 0; i < poly_n[side]; i++)
        begin
            j = (i + 1 == poly_n[side]) ? 0 : i + 1;
            ax = poly_y[side][i] - poly_y[side][j];
            ay = poly_x[side][j] - poly_x[side][i];
            for (int s = 0; s < 2; s++)
            begin
                for (int k = 0; k < poly_n[s]; k++)
                begin
                    d = poly_x[s][k] * ax + poly_y[s][k] * ay;
                    if (k == 0 || d < lo[s])
                        lo[s] = d;
                    if (k == 0 || d > hi[s])
                        hi[s] = d;
                end
            end
            if (hi[0] < lo[1] || hi[1] < lo[0])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_collision(logic side_b, coord_t x, coord_t y, logic last);
        int       s;
        verdict_t v;
        s = side_b ? 1 : 0;
        // append to a closed polygon starts a new one
        if (poly_closed[s])
        begin
            poly_n[s] = 0;
            poly_ovf[s] = 1'b0;
            poly_closed[s] = 1'b0;
        end
        if (poly_n[s] < NV)
        begin
            poly_x[s][poly_n[s]] = wrap_coord(x);
            poly_y[s][poly_n[s]] = wrap_coord(y);
            poly_n[s]++;
        end
        else
            poly_ovf[s] = 1'b1;
        if (last)
            poly_closed[s] = 1'b1;
        if (side_b == FUNC_B && last)
        begin
            v.empty = poly_n[0] == 0 || poly_n[1] == 0;
            v.collide = !v.empty && axes_overlap(0) && axes_overlap(1);
            v.overflow = poly_ovf[0] || poly_ovf[1];
            verdicts.insert(verdicts.size(), v);
        end
    endtask

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        vertex_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= FUNC_A;
            vertex_x <= '0;
            vertex_y <= '0;
            last_vertex <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_collision(func, vertex_x, vertex_y, last_vertex);
            if (!in_valid || in_ready)
            begin
                if (vertex_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = vertex_feed.pop_front();
                    in_valid <= 1'b1;
                    func <= nxt.func;
                    vertex_x <= nxt.x;
                    vertex_y <= nxt.y;
                    last_vertex <= nxt.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_seen != hold_request)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_request;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= hold_left == 0 && $urandom_range(0, 99) >= recv_stall_pct;
    end

    // result checker
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts.size() == 0)
                report_mismatch($sformatf(
                    "result with none pending: collide %0b empty %0b overflow %0b",
                    collide, empty_polygon, vertex_overflow));
            else
            begin
                want = verdicts.pop_front();
                if (collide !== want.collide)
                    report_mismatch($sformatf("collide expected %0b got %0b",
                                              want.collide, collide));
                if (empty_polygon !== want.empty)
                    report_mismatch($sformatf("empty_polygon expected %0b got %0b",
                                              want.empty, empty_polygon));
                if (vertex_overflow !== want.overflow)
                    report_mismatch($sformatf("vertex_overflow expected %0b got %0b",
                                              want.overflow, vertex_overflow));
            end
        end
    end

    function automatic int clamp16(int v);
        return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
    endfunction

    task automatic push_vertex(logic side, int x, int y, logic last);
        vertex_req_t r;
        r.func = side;
        r.x = coord_t'(clamp16(x));
        r.y = coord_t'(clamp16(y));
        r.last = last;
        vertex_feed.insert(vertex_feed.size(), r);
        fed++;
    endtask

    task automatic push_noise(int n);
        vertex_req_t r;
        for (int k = 0; k < n; k++)
        begin
            r.func = $urandom_range(0, 1) != 0;
            r.x = coord_t'($urandom());
            r.y = coord_t'($urandom());
            r.last = $urandom_range(0, 3) == 0;
            vertex_feed.insert(vertex_feed.size(), r);
            fed++;
        end
    endtask

    // convex polygon: sorted jittered angles on a circle, either winding
    task automatic push_polygon(logic side, int n, int cx, int cy, int radius, logic close);
        real base;
        real stride;
        real a;
        int  x;
        int  y;
        base = $urandom_range(0, 6283) / 1000.0;
        stride = 6.2831853 / n;
        if ($urandom_range(0, 1) != 0)
            stride = -stride;
        for (int k = 0; k < n; k++)
        begin
            a = base + stride * (k + $urandom_range(0, 60) / 100.0);
            x = cx + int'(radius * $cos(a));
            y = cy + int'(radius * $sin(a));
            push_vertex(side, x, y, close && k == n - 1);
            // repeated vertex gives a zero-length edge
            if (k < n - 1 && $urandom_range(0, 24) == 0)
                push_vertex(side, x, y, 1'b0);
        end
    endtask

    function automatic int pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return $urandom_range(1, 2);
        if (roll < 92)
            return $urandom_range(3, 6);
        return $urandom_range(12, NV + 4);
    endfunction

    function automatic int pick_radius();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20000, 30000);
        return $urandom_range(16, 3000);
    endfunction

    task automatic push_scene();
        int  ra;
        int  rb;
        int  cx;
        int  cy;
        int  gap;
        int  roll;
        real a;
        ra = pick_radius();
        rb = pick_radius();
        cx = $urandom_range(0, 40000) - 20000;
        cy = $urandom_range(0, 40000) - 20000;
        gap = $urandom_range(0, (ra + rb) * 13 / 10);
        a = $urandom_range(0, 6283) / 1000.0;
        roll = $urandom_range(0, 19);
        // mostly a fresh a; sometimes a is reused or left open
        if (roll != 0)
            push_polygon(FUNC_A, pick_size(), cx, cy, ra, roll != 1);
        push_polygon(FUNC_B, pick_size(), cx + int'(gap * $cos(a)), cy + int'(gap * $sin(a)),
                     rb, 1'b1);
    endtask

    task automatic fill_phase();
        int first;
        first = fed;
        while (fed - first < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 99) < 12)
                push_noise($urandom_range(1, 4));
            else
                push_scene();
        end
        push_scene();
    endtask

    task automatic wait_drained();
        while (vertex_feed.size() != 0 || in_valid || verdicts.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        for (int s = 0; s < 2; s++)
        begin
            poly_n[s] = 0;
            poly_closed[s] = 1'b1;
            poly_ovf[s] = 1'b0;
        end
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // a still empty after reset
        push_vertex(FUNC_B, 5, -7, 1'b1);
        // coordinate extremes
        push_vertex(FUNC_A, 32767, 32767, 1'b0);
        push_vertex(FUNC_A, -32768, 32767, 1'b0);
        push_vertex(FUNC_A, -32768, -32768, 1'b1);
        push_vertex(FUNC_B, 32767, -32768, 1'b0);
        push_vertex(FUNC_B, 0, 0, 1'b1);
        // a left open, b with a zero-length edge
        push_vertex(FUNC_A, 0, 0, 1'b0);
        push_vertex(FUNC_A, 160, 0, 1'b0);
        push_vertex(FUNC_B, 80, 80, 1'b0);
        push_vertex(FUNC_B, 80, 80, 1'b0);
        push_vertex(FUNC_B, 240, 80, 1'b1);
        // open a keeps growing, b restarts as a point inside
        push_vertex(FUNC_A, 80, 160, 1'b1);
        push_vertex(FUNC_B, 80, 40, 1'b1);
        // far apart single points
        push_vertex(FUNC_A, -32768, 32767, 1'b1);
        push_vertex(FUNC_B, 32767, -32768, 1'b1);
        // coincident points
        push_vertex(FUNC_A, 100, 100, 1'b1);
        push_vertex(FUNC_B, 100, 100, 1'b1);
        // separated triangles
        push_vertex(FUNC_A, 0, 0, 1'b0);
        push_vertex(FUNC_A, 100, 0, 1'b0);
        push_vertex(FUNC_A, 0, 100, 1'b1);
        push_vertex(FUNC_B, 200, 200, 1'b0);
        push_vertex(FUNC_B, 300, 200, 1'b0);
        push_vertex(FUNC_B, 200, 300, 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_request++;
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct = 9;
                    recv_stall_pct = 9;
                end
            endcase
            fill_phase();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && verdicts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
